// ===== design/signed_drive_to_pwm_compare_assert.svh =====
// ----------------------------------------------------------------------------
// signed drive to pwm compare: assertion macros
// shared property forms for the checker, clocked on clk, reset by rst_n
// ----------------------------------------------------------------------------
`ifndef SIGNED_DRIVE_TO_PWM_COMPARE_ASSERT_SVH
`define SIGNED_DRIVE_TO_PWM_COMPARE_ASSERT_SVH

// same-cycle implication
`define SDPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SDPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sdpc_pkg.sv =====
// ----------------------------------------------------------------------------
// sdpc_pkg
// types and constants shared by the drive to pwm compare pipeline
// ----------------------------------------------------------------------------
package sdpc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MASK_W     = 7;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLED      = 3'd0,
    CFG_INVERT       = 3'd1,
    CFG_OUTPUT_MODE  = 3'd2,
    CFG_TIMER_PERIOD = 3'd3,
    CFG_TICKS_PER_US = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_RC      = 2'd0,
    MODE_CENTER  = 2'd1,
    MODE_PWM_DIR = 2'd2,
    MODE_DUAL    = 2'd3
  } mode_t;

  localparam logic [MASK_W-1:0] MASK_NONE    = 7'h00;
  localparam logic [MASK_W-1:0] MASK_RC      = 7'h01;
  localparam logic [MASK_W-1:0] MASK_CENTER  = 7'h02;
  localparam logic [MASK_W-1:0] MASK_PWM_DIR = 7'h1C;
  localparam logic [MASK_W-1:0] MASK_DUAL    = 7'h60;

  localparam logic [15:0] DRIVE_MIN     = 16'h8000;
  localparam logic [15:0] FULL_SCALE    = 16'h7fff;
  localparam logic [15:0] LEVEL_HIGH    = 16'hffff;
  localparam logic [15:0] TICKS_Q8_RST  = 16'd512;
  localparam logic [10:0] RC_CENTER_US  = 11'd1500;
  localparam logic [10:0] RC_MIN_US     = 11'd1000;
  localparam logic [10:0] RC_MAX_US     = 11'd2000;
  localparam logic [9:0]  RC_HALF_SPAN  = 10'd500;
  localparam logic [24:0] RC_SPAN_US    = 25'd1000;

  typedef struct packed {
    logic        enabled;
    logic        invert;
    mode_t       mode;
    logic [15:0] period;
    logic [15:0] ticks_q8;
  } cfg_t;

  // products after the multiply stage
  typedef struct packed {
    logic        neg;
    logic        ctr_pos;
    logic [24:0] rc_prod;
    logic [31:0] duty_prod;
    logic [31:0] ctr_prod;
  } prod_t;

  // quotients after the divide stage
  typedef struct packed {
    logic        neg;
    logic [10:0] us;
    logic [15:0] duty;
    logic [15:0] ctr;
  } scl_t;

endpackage

// ===== design/sdpc_if.sv =====
// ----------------------------------------------------------------------------
// sdpc channel interfaces
// valid/ready channels for the drive value and the compare result
// ----------------------------------------------------------------------------
interface sdpc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] drive_value;

  modport source (output valid, output drive_value, input ready);
  modport sink   (input valid, input drive_value, output ready);
endinterface

interface sdpc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] rc_pulse_compare;
  logic [15:0] center_compare;
  logic [15:0] duty_compare;
  logic [15:0] dir_forward_level;
  logic [15:0] dir_reverse_level;
  logic [15:0] dual_forward_compare;
  logic [15:0] dual_reverse_compare;
  logic [6:0]  write_mask;

  modport source (
    output valid, output rc_pulse_compare, output center_compare,
    output duty_compare, output dir_forward_level, output dir_reverse_level,
    output dual_forward_compare, output dual_reverse_compare, output write_mask,
    input ready
  );
  modport sink (
    input valid, input rc_pulse_compare, input center_compare,
    input duty_compare, input dir_forward_level, input dir_reverse_level,
    input dual_forward_compare, input dual_reverse_compare, input write_mask,
    output ready
  );
endinterface

// ===== design/signed_drive_to_pwm_compare.sv =====
// ----------------------------------------------------------------------------
// signed_drive_to_pwm_compare: signed drive value to timer compare values
// path: an input transfer passes the registers of stages a, b, c and d to the result
// throughput: one transfer per cycle while out_ch.ready holds, set by the four-register pipeline
// reset: synchronous on rst_n, clears the pipeline, config to its defaults
// ----------------------------------------------------------------------------
module signed_drive_to_pwm_compare (
  input  logic                            clk,
  input  logic                            rst_n,
  sdpc_in_if.sink                         in_ch,
  sdpc_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [sdpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sdpc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sdpc_pkg::*;

  // pipeline:
  //   stage a  input register, holds the raw drive value
  //   stage b  inversion, magnitude and the three products
  //            (|p|*1000, |p|*period, (32767+p)*period)
  //   stage c  divides by 32767 / 65535 via shift plus remainder fold,
  //            rc pulse clip to 1000..2000 us, clamps to the period
  //   stage d  us * ticks_per_us (q8.8), saturation, mode select, result
  // every stage stalls only when it is full and the next one cannot take,
  // so bubbles are squeezed out while the output waits

  cfg_t  cfg;
  logic  mul_valid;
  logic  mul_ready;
  prod_t mul_prod;
  logic  div_valid;
  logic  div_ready;
  scl_t  div_scl;

  // config must only be written while the pipeline is empty (the block does not enforce this), so stages read it live
  sdpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sdpc_mul_stage u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_ch    (in_ch),
    .dn_valid (mul_valid),
    .dn_ready (mul_ready),
    .dn_prod  (mul_prod)
  );

  sdpc_div_stage u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (mul_valid),
    .up_ready (mul_ready),
    .up_prod  (mul_prod),
    .dn_valid (div_valid),
    .dn_ready (div_ready),
    .dn_scl   (div_scl)
  );

  // result register: the transfer on out_ch happens from here
  sdpc_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (div_valid),
    .up_ready (div_ready),
    .up_scl   (div_scl),
    .out_ch   (out_ch)
  );
endmodule

// ===== design/sdpc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// sdpc_cfg_regs
// configuration register file, write only
// ----------------------------------------------------------------------------
module sdpc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sdpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sdpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output sdpc_pkg::cfg_t                 cfg
);
  import sdpc_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled  <= 1'b0;
      cfg_r.invert   <= 1'b0;
      cfg_r.mode     <= MODE_RC;
      cfg_r.period   <= '0;
      cfg_r.ticks_q8 <= TICKS_Q8_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ENABLED:      cfg_r.enabled  <= cfg_wdata[0];
        CFG_INVERT:       cfg_r.invert   <= cfg_wdata[0];
        CFG_OUTPUT_MODE:  cfg_r.mode     <= mode_t'(cfg_wdata[1:0]);
        CFG_TIMER_PERIOD: cfg_r.period   <= cfg_wdata[15:0];
        CFG_TICKS_PER_US: cfg_r.ticks_q8 <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;
endmodule

// ===== design/sdpc_mul_stage.sv =====
// ----------------------------------------------------------------------------
// sdpc_mul_stage
// input register, inversion and magnitude, then the scaling products
// ----------------------------------------------------------------------------
module sdpc_mul_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  sdpc_pkg::cfg_t  cfg,
  sdpc_in_if.sink         in_ch,
  output logic            dn_valid,
  input  logic            dn_ready,
  output sdpc_pkg::prod_t dn_prod
);
  import sdpc_pkg::*;

  logic        va_r;
  logic [15:0] drv_r;
  logic        vb_r;
  prod_t       prod_r;
  prod_t       prod_nxt;
  logic        ready_a;
  logic        ready_b;

  logic [15:0] p;
  logic [15:0] mag;
  logic [16:0] num;

  assign ready_b     = !vb_r || dn_ready;
  assign ready_a     = !va_r || ready_b;
  assign in_ch.ready = ready_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (ready_a) begin
        va_r <= in_ch.valid;
      end
      if (ready_b) begin
        vb_r <= va_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && in_ch.valid) begin
      drv_r <= in_ch.drive_value;
    end
    if (ready_b && va_r) begin
      prod_r <= prod_nxt;
    end
  end

  always_comb begin
    // negation saturates the most negative code
    if (!cfg.invert) begin
      p = drv_r;
    end else if (drv_r == DRIVE_MIN) begin
      p = FULL_SCALE;
    end else begin
      p = 16'(~drv_r + 16'd1);
    end
    mag = p[15] ? 16'(~p + 16'd1) : p;
    num = {p[15], p} + {1'b0, FULL_SCALE};

    prod_nxt.neg       = p[15];
    prod_nxt.ctr_pos   = !num[16] && (num != 17'd0);
    prod_nxt.rc_prod   = 25'(mag) * RC_SPAN_US;
    prod_nxt.duty_prod = 32'(mag) * 32'(cfg.period);
    prod_nxt.ctr_prod  = 32'(num[15:0]) * 32'(cfg.period);
  end

  assign dn_valid = vb_r;
  assign dn_prod  = prod_r;
endmodule

// ===== design/sdpc_div_stage.sv =====
// ----------------------------------------------------------------------------
// sdpc_div_stage
// constant divides by 2^k-1 with correction, rc pulse clip, period clamps
// ----------------------------------------------------------------------------
module sdpc_div_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  sdpc_pkg::cfg_t  cfg,
  input  logic            up_valid,
  output logic            up_ready,
  input  sdpc_pkg::prod_t up_prod,
  output logic            dn_valid,
  input  logic            dn_ready,
  output sdpc_pkg::scl_t  dn_scl
);
  import sdpc_pkg::*;

  logic        v_r;
  scl_t        scl_r;
  scl_t        scl_nxt;

  logic [9:0]  rc_q0;
  logic [15:0] rc_rem;
  logic [9:0]  rc_qm;
  logic [16:0] d_q0;
  logic [17:0] d_rem;
  logic [16:0] d_q;
  logic [15:0] c_q0;
  logic [16:0] c_rem;
  logic [16:0] c_q;

  assign up_ready = !v_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      scl_r <= scl_nxt;
    end
  end

  always_comb begin
    // x / 32767: x >> 15 is low by at most two, the folded remainder fixes it
    rc_q0  = up_prod.rc_prod[24:15];
    rc_rem = {1'b0, up_prod.rc_prod[14:0]} + {6'd0, rc_q0};
    rc_qm  = rc_q0 + 10'(rc_rem >= FULL_SCALE);

    d_q0  = up_prod.duty_prod[31:15];
    d_rem = {3'd0, up_prod.duty_prod[14:0]} + {1'b0, d_q0};
    d_q   = d_q0 + 17'(d_rem >= {2'd0, FULL_SCALE})
                 + 17'(d_rem >= {1'b0, FULL_SCALE, 1'b0});

    // x / 65535, one correction step
    c_q0  = up_prod.ctr_prod[31:16];
    c_rem = {1'b0, up_prod.ctr_prod[15:0]} + {1'b0, c_q0};
    c_q   = {1'b0, c_q0} + 17'(c_rem >= {1'b0, LEVEL_HIGH});

    scl_nxt.neg = up_prod.neg;

    // pulse = 1500 - q, clipped to 1000..2000
    if (rc_qm > RC_HALF_SPAN) begin
      scl_nxt.us = up_prod.neg ? RC_MAX_US : RC_MIN_US;
    end else if (up_prod.neg) begin
      scl_nxt.us = RC_CENTER_US + {1'b0, rc_qm};
    end else begin
      scl_nxt.us = RC_CENTER_US - {1'b0, rc_qm};
    end

    scl_nxt.duty = (d_q > {1'b0, cfg.period}) ? cfg.period : d_q[15:0];

    if (!up_prod.ctr_pos) begin
      scl_nxt.ctr = '0;
    end else if (c_q > {1'b0, cfg.period}) begin
      scl_nxt.ctr = cfg.period;
    end else begin
      scl_nxt.ctr = c_q[15:0];
    end
  end

  assign dn_valid = v_r;
  assign dn_scl   = scl_r;
endmodule

// ===== design/sdpc_out_stage.sv =====
// ----------------------------------------------------------------------------
// sdpc_out_stage
// rc tick scaling, mode selection and the result register
// ----------------------------------------------------------------------------
module sdpc_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  sdpc_pkg::cfg_t cfg,
  input  logic           up_valid,
  output logic           up_ready,
  input  sdpc_pkg::scl_t up_scl,
  sdpc_out_if.source     out_ch
);
  import sdpc_pkg::*;

  logic              v_r;
  logic [15:0]       rc_r,    rc_nxt;
  logic [15:0]       ctr_r,   ctr_nxt;
  logic [15:0]       duty_r,  duty_nxt;
  logic [15:0]       dfwd_r,  dfwd_nxt;
  logic [15:0]       drev_r,  drev_nxt;
  logic [15:0]       xfwd_r,  xfwd_nxt;
  logic [15:0]       xrev_r,  xrev_nxt;
  logic [MASK_W-1:0] mask_r,  mask_nxt;

  logic [26:0] tk_full;
  logic [18:0] tk;
  logic [15:0] tk_sat;

  assign up_ready = !v_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      rc_r   <= rc_nxt;
      ctr_r  <= ctr_nxt;
      duty_r <= duty_nxt;
      dfwd_r <= dfwd_nxt;
      drev_r <= drev_nxt;
      xfwd_r <= xfwd_nxt;
      xrev_r <= xrev_nxt;
      mask_r <= mask_nxt;
    end
  end

  always_comb begin
    // microseconds times ticks per microsecond in q8.8
    tk_full = 27'(up_scl.us) * 27'(cfg.ticks_q8);
    tk      = tk_full[26:8];
    tk_sat  = (|tk[18:16]) ? LEVEL_HIGH : tk[15:0];

    rc_nxt   = '0;
    ctr_nxt  = '0;
    duty_nxt = '0;
    dfwd_nxt = '0;
    drev_nxt = '0;
    xfwd_nxt = '0;
    xrev_nxt = '0;
    mask_nxt = MASK_NONE;
    if (cfg.enabled) begin
      case (cfg.mode)
        MODE_RC: begin
          rc_nxt   = tk_sat;
          mask_nxt = MASK_RC;
        end
        MODE_CENTER: begin
          ctr_nxt  = up_scl.ctr;
          mask_nxt = MASK_CENTER;
        end
        MODE_PWM_DIR: begin
          duty_nxt = up_scl.duty;
          dfwd_nxt = up_scl.neg ? 16'd0 : LEVEL_HIGH;
          drev_nxt = up_scl.neg ? LEVEL_HIGH : 16'd0;
          mask_nxt = MASK_PWM_DIR;
        end
        MODE_DUAL: begin
          xfwd_nxt = up_scl.neg ? 16'd0 : up_scl.duty;
          xrev_nxt = up_scl.neg ? up_scl.duty : 16'd0;
          mask_nxt = MASK_DUAL;
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid                = v_r;
  assign out_ch.rc_pulse_compare     = rc_r;
  assign out_ch.center_compare       = ctr_r;
  assign out_ch.duty_compare         = duty_r;
  assign out_ch.dir_forward_level    = dfwd_r;
  assign out_ch.dir_reverse_level    = drev_r;
  assign out_ch.dual_forward_compare = xfwd_r;
  assign out_ch.dual_reverse_compare = xrev_r;
  assign out_ch.write_mask           = mask_r;
endmodule

// ===== design/sdpc_checker.sv =====
// ----------------------------------------------------------------------------
// sdpc_checker
// port-level checks on the compare result channel
// ----------------------------------------------------------------------------
`include "signed_drive_to_pwm_compare_assert.svh"

module sdpc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] rc_pulse_compare,
  input logic [15:0] center_compare,
  input logic [15:0] duty_compare,
  input logic [15:0] dir_forward_level,
  input logic [15:0] dir_reverse_level,
  input logic [15:0] dual_forward_compare,
  input logic [15:0] dual_reverse_compare,
  input logic [6:0]  write_mask
);
  import sdpc_pkg::*;

  logic [15:0] any_field;

  assign any_field = rc_pulse_compare | center_compare | duty_compare
                   | dir_forward_level | dir_reverse_level
                   | dual_forward_compare | dual_reverse_compare;

  `SDPC_ASSERT_IMP(a_mask_legal, out_valid,
    write_mask == MASK_NONE || write_mask == MASK_RC || write_mask == MASK_CENTER ||
    write_mask == MASK_PWM_DIR || write_mask == MASK_DUAL,
    "write mask is not one of the mode masks")

  `SDPC_ASSERT_IMP(a_idle_zero, out_valid && write_mask == MASK_NONE,
    any_field == 16'd0, "disabled result carries a nonzero field")

  `SDPC_ASSERT_IMP(a_dir_compl, out_valid && write_mask == MASK_PWM_DIR,
    (dir_forward_level == LEVEL_HIGH && dir_reverse_level == 16'd0) ||
    (dir_forward_level == 16'd0 && dir_reverse_level == LEVEL_HIGH),
    "direction levels not complementary")

  `SDPC_ASSERT_NXT(a_stall_hold, out_valid && !out_ready,
    out_valid && $stable(write_mask) && $stable(any_field) &&
    $stable(duty_compare),
    "stalled result changed")
endmodule

bind signed_drive_to_pwm_compare sdpc_checker u_sdpc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .rc_pulse_compare     (out_ch.rc_pulse_compare),
  .center_compare       (out_ch.center_compare),
  .duty_compare         (out_ch.duty_compare),
  .dir_forward_level    (out_ch.dir_forward_level),
  .dir_reverse_level    (out_ch.dir_reverse_level),
  .dual_forward_compare (out_ch.dual_forward_compare),
  .dual_reverse_compare (out_ch.dual_reverse_compare),
  .write_mask           (out_ch.write_mask)
);

// ===== dv/signed_drive_to_pwm_compare_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_drive_to_pwm_compare_tb
// drives signed drive values through the compare mapper under a series of
// register settings (all four modes, inversion, disabled output, period and
// q8.8 tick scale extremes) and checks every compare result field by field
// against an in-bench prediction, with random idle cycles on both channels
// ----------------------------------------------------------------------------
module signed_drive_to_pwm_compare_tb;
  import sdpc_pkg::*;

  // arithmetic constants in signed int form for the prediction
  localparam int FULL    = int'(FULL_SCALE);
  localparam int LEVEL   = int'(LEVEL_HIGH);
  localparam int US_MID  = int'(RC_CENTER_US);
  localparam int US_LO   = int'(RC_MIN_US);
  localparam int US_HI   = int'(RC_MAX_US);
  localparam int SPAN_US = int'(RC_SPAN_US);

  // one compare result, fields in write_mask bit order
  typedef struct packed {
    logic [15:0]       rc_pulse;
    logic [15:0]       center;
    logic [15:0]       duty;
    logic [15:0]       dir_fwd;
    logic [15:0]       dir_rev;
    logic [15:0]       dual_fwd;
    logic [15:0]       dual_rev;
    logic [MASK_W-1:0] mask;
  } compare_t;

  // --------------------------------------------------------------------------
  // compare scoreboard: register shadow, mapping prediction, pending results
  // --------------------------------------------------------------------------
  class pwm_compare_scoreboard;
    logic        enabled;
    logic        invert;
    mode_t       mode;
    logic [15:0] period;
    logic [15:0] ticks_q8;
    compare_t    expected_q[$];
    int          errors;
    int          checked;
    int          accepted;
    int          disabled_items;
    int          mode_items[4];

    function new();
      enabled  = 1'b0;
      invert   = 1'b0;
      mode     = MODE_RC;
      period   = '0;
      ticks_q8 = TICKS_Q8_RST;
      errors   = 0;
      checked  = 0;
      accepted = 0;
      disabled_items = 0;
      foreach (mode_items[i]) mode_items[i] = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [15:0] v);
      case (idx)
        CFG_ENABLED:      enabled  = v[0];
        CFG_INVERT:       invert   = v[0];
        CFG_OUTPUT_MODE:  mode     = mode_t'(v[1:0]);
        CFG_TIMER_PERIOD: period   = v;
        CFG_TICKS_PER_US: ticks_q8 = v;
        default: ;
      endcase
    endfunction

    function int unsigned scale_duty(int p);
      longint mag;
      longint d;
      mag = (p < 0) ? -p : p;
      d = (mag * longint'(period)) / FULL;
      return (d > longint'(period)) ? int'(period) : int'(d);
    endfunction

    function compare_t map_drive(logic signed [15:0] drive);
      compare_t r;
      int       p;
      int       q;
      int       us;
      int       num;
      longint   ticks;
      longint   c;
      r = '0;
      if (!enabled) return r;
      p = drive;
      // negating the most negative drive saturates
      if (invert) p = (p == -32768) ? FULL : -p;
      case (mode)
        MODE_RC: begin
          q  = (p * SPAN_US) / FULL;
          us = US_MID - q;
          if (us < US_LO) us = US_LO;
          if (us > US_HI) us = US_HI;
          ticks = (longint'(us) * longint'(ticks_q8)) >>> 8;
          r.rc_pulse = (ticks > LEVEL) ? LEVEL_HIGH : ticks[15:0];
          r.mask     = MASK_RC;
        end
        MODE_CENTER: begin
          num = FULL + p;
          c   = 0;
          if (num > 0) c = (longint'(num) * longint'(period)) / LEVEL;
          if (c > longint'(period)) c = longint'(period);
          r.center = c[15:0];
          r.mask   = MASK_CENTER;
        end
        MODE_PWM_DIR: begin
          r.duty    = 16'(scale_duty(p));
          r.dir_fwd = (p < 0) ? 16'h0000 : LEVEL_HIGH;
          r.dir_rev = (p < 0) ? LEVEL_HIGH : 16'h0000;
          r.mask    = MASK_PWM_DIR;
        end
        default: begin
          r.dual_fwd = (p < 0) ? 16'h0000 : 16'(scale_duty(p));
          r.dual_rev = (p < 0) ? 16'(scale_duty(p)) : 16'h0000;
          r.mask     = MASK_DUAL;
        end
      endcase
      return r;
    endfunction

    function void note_drive(logic signed [15:0] drive);
      accepted++;
      if (enabled) mode_items[int'(mode)]++;
      else disabled_items++;
      expected_q.push_back(map_drive(drive));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_field(string name, logic [15:0] got, logic [15:0] exp);
      if (got !== exp)
        report($sformatf("%s got %0d expected %0d (result %0d)", name, got, exp, checked));
    endtask

    task check_result(compare_t got);
      compare_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected compare result, mask %0h", got.mask));
        return;
      end
      e = expected_q.pop_front();
      check_field("rc_pulse_compare", got.rc_pulse, e.rc_pulse);
      check_field("center_compare", got.center, e.center);
      check_field("duty_compare", got.duty, e.duty);
      check_field("dir_forward_level", got.dir_fwd, e.dir_fwd);
      check_field("dir_reverse_level", got.dir_rev, e.dir_rev);
      check_field("dual_forward_compare", got.dual_fwd, e.dual_fwd);
      check_field("dual_reverse_compare", got.dual_rev, e.dual_rev);
      check_field("write_mask", 16'(got.mask), 16'(e.mask));
      checked++;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // random idling on the drive side and stalls on the result side
  logic gaps_on;
  logic stall_on;

  pwm_compare_scoreboard sb;

  sdpc_in_if  in_ch();
  sdpc_out_if out_ch();

  signed_drive_to_pwm_compare u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit, far above the slowest legal run
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // result side ready: drops with a chance of about 19 in a hundred when enabled
  always @(posedge clk) begin
    if (!stall_on) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= 19);
    end
  end

  // drive transfers feed the prediction, taken with the values before this edge
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_drive(in_ch.drive_value);
  end

  // result transfers are checked against the oldest prediction
  always @(posedge clk) begin
    compare_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.rc_pulse = out_ch.rc_pulse_compare;
      got.center   = out_ch.center_compare;
      got.duty     = out_ch.duty_compare;
      got.dir_fwd  = out_ch.dir_forward_level;
      got.dir_rev  = out_ch.dir_reverse_level;
      got.dual_fwd = out_ch.dual_forward_compare;
      got.dual_rev = out_ch.dual_reverse_compare;
      got.mask     = out_ch.write_mask;
      sb.check_result(got);
    end
  end

  // --------------------------------------------------------------------------
  // driver tasks, all entered and left at a rising edge
  // --------------------------------------------------------------------------

  // register write: write enable stays high for back to back writes,
  // the caller drops it after the last one
  task write_reg(input cfg_idx_t idx, input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  // full register set; narrow registers get junk in their unused upper bits
  task program_cfg(input logic en, input logic inv, input mode_t m,
                   input logic [15:0] period, input logic [15:0] ticks);
    logic [15:0] junk;
    junk = 16'($urandom);
    write_reg(CFG_ENABLED, {junk[15:1], en});
    write_reg(CFG_INVERT, {junk[14:0], inv});
    write_reg(CFG_OUTPUT_MODE, {junk[13:0], m});
    write_reg(CFG_TIMER_PERIOD, period);
    write_reg(CFG_TICKS_PER_US, ticks);
    cfg_we <= 1'b0;
  endtask

  // one drive transfer, with optional idle cycles ahead of it
  task send_drive(input logic signed [15:0] v);
    while (gaps_on && $urandom_range(0, 99) < 19) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.drive_value <= v;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // drop valid, let every result drain, then idle before returning;
  // the queue is checked only after an edge, so the last transfer is already in it
  task wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task send_list(input logic signed [15:0] vals[$]);
    foreach (vals[i]) send_drive(vals[i]);
    wait_idle();
  endtask

  // random drive: corners, the rc clip knee, values near zero, full range
  function automatic logic signed [15:0] pick_drive();
    int sel;
    int v;
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      case ($urandom_range(0, 5))
        0: v = -32768;
        1: v = -32767;
        2: v = -1;
        3: v = 0;
        4: v = 1;
        default: v = FULL;
      endcase
    end else if (sel < 22) begin
      // around where the rc pulse reaches its clip limits
      v = $urandom_range(16300, 16500);
      if ($urandom_range(0, 1)) v = -v;
    end else if (sel < 40) begin
      v = int'($urandom_range(0, 200)) - 100;
    end else begin
      v = $urandom_range(0, 65535);
    end
    return 16'(v);
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic signed [15:0] dv[$];
    logic [15:0]        period_sel;
    logic [15:0]        ticks_sel;
    mode_t              mode_sel;
    int                 n_items;

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.drive_value = '0;
    out_ch.ready      = 1'b0;
    gaps_on           = 1'b1;
    stall_on          = 1'b1;
    sb = new();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: output disabled, every field and the mask stay zero
    dv = '{-32768, 0, 32767};
    send_list(dv);

    // enable only: rc mode with the default q8.8 scale of two ticks per us
    write_reg(CFG_ENABLED, 16'd1);
    cfg_we <= 1'b0;
    dv = '{-32768, -16384, 0, 16384, 32767};
    send_list(dv);

    // inverted most negative drive saturates, rc ticks saturate at full scale
    program_cfg(1'b1, 1'b1, MODE_RC, 16'd0, 16'hffff);
    dv = '{-32768, 0};
    send_list(dv);

    // centered: negative numerator at the most negative drive gives zero
    program_cfg(1'b1, 1'b0, MODE_CENTER, 16'hffff, TICKS_Q8_RST);
    dv = '{-32768, -1, 0, 32767};
    send_list(dv);

    // pwm plus direction: duty of the most negative drive clamps to the period
    program_cfg(1'b1, 1'b0, MODE_PWM_DIR, 16'hffff, TICKS_Q8_RST);
    dv = '{-32768, -1, 0, 32767};
    send_list(dv);

    // dual with inversion: duty swaps between forward and reverse channels
    program_cfg(1'b1, 1'b1, MODE_DUAL, 16'd1000, TICKS_Q8_RST);
    dv = '{-32768, -5, 0, 5};
    send_list(dv);

    // random phases; the early ones sweep period and tick scale extremes,
    // one is a long stretch with no idling on either side
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin period_sel = 16'hffff; ticks_sel = 16'hffff; end
        1: begin period_sel = 16'h0000; ticks_sel = 16'h0000; end
        2: begin period_sel = 16'h0001; ticks_sel = TICKS_Q8_RST; end
        3: begin period_sel = FULL_SCALE; ticks_sel = 16'h0001; end
        4: begin period_sel = 16'd1000; ticks_sel = 16'h0100; end
        5: begin period_sel = 16'hffff; ticks_sel = 16'hffff; end
        default: begin
          period_sel = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 300))
                                                   : 16'($urandom);
          ticks_sel  = 16'($urandom);
        end
      endcase
      mode_sel = (ph < 8) ? mode_t'(ph % 4) : mode_t'($urandom_range(0, 3));
      program_cfg((ph != 7) && ($urandom_range(0, 9) != 0), 1'($urandom_range(0, 1)),
                  mode_sel, period_sel, ticks_sel);
      gaps_on  = (ph != 5);
      stall_on = (ph != 5);
      n_items  = (ph == 5) ? 200 : 100;
      repeat (n_items) send_drive(pick_drive());
      wait_idle();
    end

    repeat (8) @(posedge clk);
    $display("coverage: %0d drive transfers, %0d results checked, %0d disabled",
             sb.accepted, sb.checked, sb.disabled_items);
    $display("per mode: rc %0d, centered %0d, pwm/dir %0d, dual %0d",
             sb.mode_items[0], sb.mode_items[1], sb.mode_items[2], sb.mode_items[3]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
